/* rtl/assert_macros.svh */
// Assertion helpers, clocked on i_clk and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define A_IMPLY(lbl, a, c) lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
    (a) |-> (c)) else $error("assertion failed");

// Next-cycle implication.
`define A_NEXT(lbl, a, c) lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
    (a) |=> (c)) else $error("assertion failed");

`endif

/* rtl/trtr_pkg.sv */
package trtr_pkg;

    localparam int MAX_RULES_DEF  = 64;
    localparam int MAX_CONDS_DEF  = 4;
    localparam int MAX_TOKENS_DEF = 64;
    localparam int NUM_ATTRS_DEF  = 4;

    // Results per run never exceed this.
    localparam int RESULT_LIMIT = 64;
    localparam int TAG_ATTR_RST = 3;

    typedef enum logic [1:0] {
        CMD_COND = 2'd0,
        CMD_ANS  = 2'd1,
        CMD_TOK  = 2'd2,
        CMD_RUN  = 2'd3
    } t_cmd;

    typedef enum logic {
        CFG_RULE_COUNT = 1'b0,
        CFG_TAG_ATTR   = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic        en;
        logic [4:0]  off;
        logic [1:0]  attr;
        logic [15:0] value;
    } t_cond;

endpackage

/* rtl/trtr_ram.sv */
module trtr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                     i_wr_data,
    input  logic                                 i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/tbl_rule_tag_rewriter.sv */
// Load commands give no result.
// In a run the sequencer steps through each rule and, at each token position, one condition
// at a time through the condition and token memories; it then emits one result per token,
// held through output stalls. No new item is taken meanwhile. Synchronous active-low reset
// clears control state, all condition valid bits and the rule count, and sets the tag
// attribute to 3; answer and token memories hold undefined data until written.
module tbl_rule_tag_rewriter #(
    parameter int MAX_RULES  = trtr_pkg::MAX_RULES_DEF,
    parameter int MAX_CONDS  = trtr_pkg::MAX_CONDS_DEF,
    parameter int MAX_TOKENS = trtr_pkg::MAX_TOKENS_DEF,
    parameter int NUM_ATTRS  = trtr_pkg::NUM_ATTRS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [5:0]  i_rule_slot,
    input  logic [1:0]  i_cond_slot,
    input  logic        i_cond_enable,
    input  logic signed [4:0] i_cond_offset,
    input  logic [1:0]  i_attr_select,
    input  logic [15:0] i_data_value,
    input  logic [5:0]  i_token_slot,
    input  logic [6:0]  i_sentence_length,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [5:0]  o_out_position,
    output logic [15:0] o_out_tag,
    output logic        o_out_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [6:0]  i_cfg_data
);

    `include "assert_macros.svh"

    localparam int LEN_LIM = (MAX_TOKENS < trtr_pkg::RESULT_LIMIT) ?
                             MAX_TOKENS : trtr_pkg::RESULT_LIMIT;
    localparam int RIW     = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int RCW     = $clog2(MAX_RULES + 1);
    localparam int CIW     = (MAX_CONDS > 1) ? $clog2(MAX_CONDS) : 1;
    localparam int PIW     = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
    localparam int PCW     = $clog2(LEN_LIM + 1);
    localparam int AIW     = (NUM_ATTRS > 1) ? $clog2(NUM_ATTRS) : 1;
    localparam int AT_W    = ((PCW > 5) ? PCW : 5) + 1;
    localparam int CDEPTH  = MAX_RULES * (2 ** CIW);
    localparam int TDEPTH  = MAX_TOKENS * (2 ** AIW);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_RULE  = 10'b0000000010,
        S_ANS   = 10'b0000000100,
        S_CRD   = 10'b0000001000,
        S_CEV   = 10'b0000010000,
        S_CCMP  = 10'b0000100000,
        S_APPLY = 10'b0001000000,
        S_ORD   = 10'b0010000000,
        S_OCAP  = 10'b0100000000,
        S_OSEND = 10'b1000000000
    } t_state;

    t_state            r_state;
    logic [6:0]        r_rule_count;
    logic [1:0]        r_tag_attr;
    logic [CDEPTH-1:0] r_cond_vld;
    logic              r_cvld;
    logic [RCW-1:0]    r_nr;
    logic [RCW-1:0]    r_rule;
    logic [CIW-1:0]    r_cond;
    logic [PCW-1:0]    r_pos;
    logic [PCW-1:0]    r_len;
    logic              r_match;
    logic [15:0]       r_ans;
    logic              r_out_vld;
    logic [15:0]       r_out_tag;

    logic                   in_acc;
    trtr_pkg::t_cmd         cmd;
    logic                   cond_wr, ans_wr, tokld_wr, apply_wr, tag_ok;
    trtr_pkg::t_cond        cond_wdata, cond_rdata;
    logic [RIW+CIW-1:0]     cond_waddr, cond_raddr;
    logic [15:0]            ans_rdata, tok_rdata, tok_wdata;
    logic [PIW+AIW-1:0]     tok_waddr, tok_raddr;
    logic                   tok_rd_en;
    logic signed [AT_W-1:0] at;
    logic                   c_en, c_in, c_attr_ok, c_last, p_last;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign cmd         = trtr_pkg::t_cmd'(i_command);
    assign tag_ok      = 32'(r_tag_attr) < NUM_ATTRS;

    assign cond_wr  = in_acc && (cmd == trtr_pkg::CMD_COND) && (32'(i_rule_slot) < MAX_RULES)
                      && (32'(i_cond_slot) < MAX_CONDS);
    assign ans_wr   = in_acc && (cmd == trtr_pkg::CMD_ANS) && (32'(i_rule_slot) < MAX_RULES);
    assign tokld_wr = in_acc && (cmd == trtr_pkg::CMD_TOK) && (32'(i_token_slot) < MAX_TOKENS)
                      && (32'(i_attr_select) < NUM_ATTRS);
    assign apply_wr = (r_state == S_APPLY) && r_match && tag_ok;

    assign cond_wdata = '{en: i_cond_enable, off: i_cond_offset, attr: i_attr_select,
                          value: i_data_value};
    assign cond_waddr = {RIW'(i_rule_slot), CIW'(i_cond_slot)};
    assign cond_raddr = {RIW'(r_rule), r_cond};

    // Evaluate the condition whose entry was read last cycle.
    assign at        = $signed({{(AT_W - PCW){1'b0}}, r_pos})
                     + $signed({{(AT_W - 5){cond_rdata.off[4]}}, cond_rdata.off});
    assign c_en      = r_cvld && cond_rdata.en;
    assign c_in      = !at[AT_W-1] && (at < $signed({{(AT_W - PCW){1'b0}}, r_len}));
    assign c_attr_ok = 32'(cond_rdata.attr) < NUM_ATTRS;
    assign c_last    = (r_cond == CIW'(MAX_CONDS - 1));
    assign p_last    = (32'(r_pos) + 1 == 32'(r_len));

    assign tok_waddr = apply_wr ? {PIW'(r_pos), AIW'(r_tag_attr)}
                                : {PIW'(i_token_slot), AIW'(i_attr_select)};
    assign tok_wdata = apply_wr ? r_ans : i_data_value;
    assign tok_raddr = (r_state == S_ORD) ? {PIW'(r_pos), AIW'(r_tag_attr)}
                                          : {PIW'(at[AT_W-2:0]), AIW'(cond_rdata.attr)};
    assign tok_rd_en = (r_state == S_ORD)
                     || ((r_state == S_CEV) && c_en && c_in && c_attr_ok);

    trtr_ram #(.WIDTH($bits(trtr_pkg::t_cond)), .DEPTH(CDEPTH)) u_cond_ram (
        .i_clk     (i_clk),
        .i_wr_en   (cond_wr),
        .i_wr_addr (cond_waddr),
        .i_wr_data (cond_wdata),
        .i_rd_en   (r_state == S_CRD),
        .i_rd_addr (cond_raddr),
        .o_rd_data (cond_rdata)
    );

    trtr_ram #(.WIDTH(16), .DEPTH(MAX_RULES)) u_ans_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ans_wr),
        .i_wr_addr (RIW'(i_rule_slot)),
        .i_wr_data (i_data_value),
        .i_rd_en   (r_state == S_RULE),
        .i_rd_addr (RIW'(r_rule)),
        .o_rd_data (ans_rdata)
    );

    trtr_ram #(.WIDTH(16), .DEPTH(TDEPTH)) u_tok_ram (
        .i_clk     (i_clk),
        .i_wr_en   (tokld_wr || apply_wr),
        .i_wr_addr (tok_waddr),
        .i_wr_data (tok_wdata),
        .i_rd_en   (tok_rd_en),
        .i_rd_addr (tok_raddr),
        .o_rd_data (tok_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_rule_count <= '0;
            r_tag_attr   <= 2'(trtr_pkg::TAG_ATTR_RST);
            r_cond_vld   <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (trtr_pkg::t_cfg_idx'(i_cfg_index))
                    trtr_pkg::CFG_RULE_COUNT: r_rule_count <= i_cfg_data;
                    trtr_pkg::CFG_TAG_ATTR:   r_tag_attr   <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (cond_wr) begin
                r_cond_vld[cond_waddr] <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && (cmd == trtr_pkg::CMD_RUN) && (i_sentence_length != '0)) begin
                        r_len  <= (32'(i_sentence_length) > LEN_LIM) ?
                                  PCW'(LEN_LIM) : PCW'(i_sentence_length);
                        r_nr   <= (32'(r_rule_count) > MAX_RULES) ?
                                  RCW'(MAX_RULES) : RCW'(r_rule_count);
                        r_rule <= '0;
                        r_state <= S_RULE;
                    end
                end
                S_RULE: begin
                    r_pos <= '0;
                    if (r_rule >= r_nr) begin
                        r_state <= S_ORD;
                    end else begin
                        r_state <= S_ANS;
                    end
                end
                S_ANS: begin
                    r_ans   <= ans_rdata;
                    r_cond  <= '0;
                    r_match <= 1'b1;
                    r_state <= S_CRD;
                end
                S_CRD: begin
                    r_cvld  <= r_cond_vld[cond_raddr];
                    r_state <= S_CEV;
                end
                S_CEV: begin
                    if (c_en && !(c_in && c_attr_ok)) begin
                        r_match <= 1'b0;
                        r_state <= S_APPLY;
                    end else if (c_en) begin
                        r_state <= S_CCMP;
                    end else if (c_last) begin
                        r_state <= S_APPLY;
                    end else begin
                        r_cond  <= r_cond + 1'b1;
                        r_state <= S_CRD;
                    end
                end
                S_CCMP: begin
                    if (tok_rdata != cond_rdata.value) begin
                        r_match <= 1'b0;
                        r_state <= S_APPLY;
                    end else if (c_last) begin
                        r_state <= S_APPLY;
                    end else begin
                        r_cond  <= r_cond + 1'b1;
                        r_state <= S_CRD;
                    end
                end
                S_APPLY: begin
                    r_cond  <= '0;
                    r_match <= 1'b1;
                    if (p_last) begin
                        r_rule  <= r_rule + 1'b1;
                        r_state <= S_RULE;
                    end else begin
                        r_pos   <= r_pos + 1'b1;
                        r_state <= S_CRD;
                    end
                end
                S_ORD: begin
                    r_state <= S_OCAP;
                end
                S_OCAP: begin
                    r_out_tag <= tag_ok ? tok_rdata : '0;
                    r_out_vld <= 1'b1;
                    r_state   <= S_OSEND;
                end
                S_OSEND: begin
                    // Hold the result until the transfer completes.
                    if (i_out_ready) begin
                        r_out_vld <= 1'b0;
                        if (p_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_pos   <= r_pos + 1'b1;
                            r_state <= S_ORD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_out_position = 6'(r_pos);
    assign o_out_tag      = r_out_tag;
    assign o_out_last     = p_last;

    `A_IMPLY(a_no_out_when_idle, o_in_ready, !o_out_valid)
    `A_NEXT(a_last_returns_idle, o_out_valid && i_out_ready && o_out_last, o_in_ready)
    `A_IMPLY(a_pos_in_range, !o_in_ready && (r_state != S_RULE), r_pos < r_len)
    `A_IMPLY(a_apply_tag_ok, apply_wr, tag_ok && (r_state == S_APPLY))

endmodule
